### rtl/serial_flash_loader_protocol_macros.svh
// Assertion macros shared by the protocol checker.
// No dependencies.
`ifndef SERIAL_FLASH_LOADER_PROTOCOL_MACROS_SVH
`define SERIAL_FLASH_LOADER_PROTOCOL_MACROS_SVH
// implication checked every clock, off during reset
`define SFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/sflp_pkg.sv
// Shared types and constants for the serial flash loader protocol engine.
// No dependencies.
`timescale 1ns / 1ps
package sflp_pkg;
    localparam logic [2:0] ACT_SEND  = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_ERASE = 3'd2;
    localparam logic [2:0] ACT_FILL  = 3'd3;
    localparam logic [2:0] ACT_WRITE = 3'd4;
    localparam logic [2:0] ACT_RWW   = 3'd5;
    localparam logic [2:0] ACT_WDT   = 3'd6;

    localparam logic [7:0] CMD_GET_PARAM   = 8'h41;
    localparam logic [7:0] CMD_SET_DEV     = 8'h42;
    localparam logic [7:0] CMD_SET_DEV_EXT = 8'h45;
    localparam logic [7:0] CMD_LEAVE       = 8'h51;
    localparam logic [7:0] CMD_LOAD_ADDR   = 8'h55;
    localparam logic [7:0] CMD_UNIVERSAL   = 8'h56;
    localparam logic [7:0] CMD_PROG_PAGE   = 8'h64;
    localparam logic [7:0] CMD_READ_PAGE   = 8'h74;
    localparam logic [7:0] CMD_READ_SIGN   = 8'h75;
    localparam logic [7:0] EOP_BYTE        = 8'h20;
    localparam logic [7:0] RESP_INSYNC     = 8'h14;
    localparam logic [7:0] RESP_OK         = 8'h10;
    localparam logic [7:0] PARM_MAJOR      = 8'h81;
    localparam logic [7:0] PARM_MINOR      = 8'h82;
    localparam logic [7:0] VAL_PARAM_YES   = 8'h04;
    localparam logic [7:0] VAL_PARAM_NO    = 8'h03;
    localparam logic [7:0] VAL_UNIV        = 8'h00;
    localparam logic [7:0] SKIP_SET_DEV    = 8'h14;
    localparam logic [7:0] SKIP_SET_DEV_EXT = 8'h05;
    localparam logic [7:0] SKIP_UNIV       = 8'h04;

    localparam logic [1:0] REG_SIG_FIRST  = 2'd0;
    localparam logic [1:0] REG_SIG_SECOND = 2'd1;
    localparam logic [1:0] REG_SIG_THIRD  = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SET_ARG,      // arg <= skip value
        OP_ARG_DEC,
        OP_ARG_LOAD,     // arg <= byte
        OP_CURSOR_LOAD,
        OP_PAGE_LEN,
        OP_READ_CNT,
        OP_ERASE_START,  // arg <= 0
        OP_STORE,        // buffer write, arg++
        OP_READ_DEC,
        OP_CURSOR_INC,
        OP_FILL_START,   // fill index <= 0
        OP_FILL_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [7:0] arg_value;
    } dp_cmd_t;

    typedef struct packed {
        logic [7:0]  arg;
        logic [7:0]  page_length;
        logic [7:0]  read_remaining;
        logic [15:0] cursor;
        logic [15:0] fill_address;
        logic [15:0] fill_word;
        logic        fill_done;
        logic        arg_next_eq_len;
    } dp_status_t;
endpackage

### rtl/sflp_datapath.sv
// Datapath: cursor, counters and the page buffer with its fill walker.
// Depends on sflp_pkg.
`timescale 1ns / 1ps
module sflp_datapath
    import sflp_pkg::*;
#(
    parameter int PAGE_BYTES = 64
)(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd_in,
    input  logic [7:0] byte_in,
    output dp_status_t status
);
    localparam int IW = $clog2(PAGE_BYTES);
    localparam logic [7:0] PB = 8'(PAGE_BYTES);

    logic [7:0]            arg_reg, arg_next;
    logic [7:0]            plen_reg, plen_next;
    logic [7:0]            rrem_reg, rrem_next;
    logic [15:0]           cursor_reg, cursor_next;
    logic [7:0]            fidx_reg, fidx_next;
    logic [7:0]            store_mem [PAGE_BYTES];
    logic [PAGE_BYTES-1:0] written_reg;
    logic [7:0]            lo_rd_reg, hi_rd_reg;
    logic                  lo_ok_reg, hi_ok_reg;
    logic [7:0]            rd_lo_idx, rd_hi_idx;
    logic                  store_en;
    logic [7:0]            lo_byte, hi_byte;

    // buffer reads follow the next fill index, so the registered bytes match fidx_reg
    assign store_en  = (cmd_in.op == OP_STORE) && (arg_reg < PB);
    assign rd_lo_idx = fidx_next;
    assign rd_hi_idx = fidx_next + 8'd1;
    assign lo_byte   = lo_ok_reg ? lo_rd_reg : 8'd0;
    assign hi_byte   = hi_ok_reg ? hi_rd_reg : 8'd0;

    always_comb
    begin
        arg_next    = arg_reg;
        plen_next   = plen_reg;
        rrem_next   = rrem_reg;
        cursor_next = cursor_reg;
        fidx_next   = fidx_reg;
        case (cmd_in.op)
            OP_SET_ARG:     arg_next = cmd_in.arg_value;
            OP_ARG_DEC:     arg_next = arg_reg - 8'd1;
            OP_ARG_LOAD:    arg_next = byte_in;
            OP_CURSOR_LOAD: cursor_next = {byte_in[6:0], arg_reg, 1'b0};
            OP_PAGE_LEN:    plen_next = byte_in;
            OP_READ_CNT:    rrem_next = byte_in;
            OP_ERASE_START: arg_next = 8'd0;
            OP_STORE:       arg_next = arg_reg + 8'd1;
            OP_READ_DEC:    rrem_next = rrem_reg - 8'd1;
            OP_CURSOR_INC:  cursor_next = cursor_reg + 16'd1;
            OP_FILL_START:  fidx_next = 8'd0;
            OP_FILL_NEXT:   fidx_next = fidx_reg + 8'd2;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_reg    <= '0;
            plen_reg   <= '0;
            rrem_reg   <= '0;
            cursor_reg <= '0;
            fidx_reg   <= '0;
        end
        else
        begin
            arg_reg    <= arg_next;
            plen_reg   <= plen_next;
            rrem_reg   <= rrem_next;
            cursor_reg <= cursor_next;
            fidx_reg   <= fidx_next;
        end
    end

    // written flags: entries never stored read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            lo_ok_reg   <= 1'b0;
            hi_ok_reg   <= 1'b0;
        end
        else
        begin
            if (store_en)
                written_reg[arg_reg[IW-1:0]] <= 1'b1;
            lo_ok_reg <= (rd_lo_idx < PB) && written_reg[rd_lo_idx[IW-1:0]];
            hi_ok_reg <= (rd_hi_idx < PB) && written_reg[rd_hi_idx[IW-1:0]];
        end
    end

    // page buffer
    always_ff @(posedge clk)
    begin
        if (store_en)
            store_mem[arg_reg[IW-1:0]] <= byte_in;
        if (rd_lo_idx < PB)
            lo_rd_reg <= store_mem[rd_lo_idx[IW-1:0]];
        if (rd_hi_idx < PB)
            hi_rd_reg <= store_mem[rd_hi_idx[IW-1:0]];
    end

    always_comb
    begin
        status.arg             = arg_reg;
        status.page_length     = plen_reg;
        status.read_remaining  = rrem_reg;
        status.cursor          = cursor_reg;
        status.fill_address    = cursor_reg + {8'd0, fidx_reg};
        status.fill_word       = {hi_byte, lo_byte};
        status.fill_done       = ({1'b0, fidx_reg} + 9'd2) >= {1'b0, PB};
        status.arg_next_eq_len = (arg_reg + 8'd1) == plen_reg;
    end
endmodule

### rtl/sflp_controller.sv
// Command state machine: sequences the protocol phases and emits result items.
// Depends on sflp_pkg.
`timescale 1ns / 1ps
module sflp_controller
    import sflp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_cmd,
    input  logic [7:0]  in_byte,
    input  logic [7:0]  sig_first,
    input  logic [7:0]  sig_second,
    input  logic [7:0]  sig_third,
    input  dp_status_t  status,
    output dp_cmd_t     dp_cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_action,
    output logic [7:0]  out_send,
    output logic [15:0] out_addr,
    output logic [15:0] out_word,
    output logic        out_last
);
    typedef enum logic [4:0] {
        PH_CMD, PH_PARAM_ARG, PH_SKIP_PLAIN, PH_SKIP_UNIV, PH_LOAD_LO, PH_LOAD_HI,
        PH_PROG_HI, PH_PROG_LO, PH_PROG_MEM, PH_PROG_DATA, PH_READ_HI, PH_READ_CNT,
        PH_READ_MEM, PH_READ_STREAM, PH_SYNC_YES, PH_SYNC_NO, PH_SYNC_PLAIN,
        PH_SYNC_UNIV, PH_SYNC_PROG, PH_SYNC_READ, PH_SYNC_SIGN, PH_SYNC_LEAVE
    } phase_t;

    // emission sequencer steps
    typedef enum logic [3:0] {
        EM_IDLE, EM_INSYNC, EM_VAL, EM_SIG2, EM_SIG3, EM_FILL, EM_WRITE,
        EM_RWW, EM_OK, EM_READ, EM_FLASH
    } em_t;

    phase_t      phase_reg, phase_next;
    em_t         em_reg, em_next;
    logic        halted_reg, halted_next;
    logic        ov_reg, ov_next;
    logic [2:0]  act_reg, act_next;
    logic [7:0]  send_reg, send_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic [7:0]  val_reg, val_next;
    logic [7:0]  fbyte_reg, fbyte_next;
    logic        space;

    assign space    = !ov_reg || out_ready;
    assign in_ready = (em_reg == EM_IDLE) && !ov_reg;

    always_comb
    begin
        phase_t ph;
        ph          = phase_reg;
        phase_next  = phase_reg;
        em_next     = em_reg;
        halted_next = halted_reg;
        ov_next     = ov_reg && !out_ready;
        act_next    = act_reg;
        send_next   = send_reg;
        addr_next   = addr_reg;
        word_next   = word_reg;
        last_next   = last_reg;
        val_next    = val_reg;
        fbyte_next  = fbyte_reg;
        dp_cmd.op        = OP_NONE;
        dp_cmd.arg_value = '0;

        if (em_reg == EM_IDLE)
        begin
            if (in_valid && in_ready && !halted_reg)
            begin
                if (in_cmd)
                begin
                    if (phase_reg == PH_READ_STREAM)
                    begin
                        fbyte_next = in_byte;
                        em_next    = EM_FLASH;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_CMD:
                        begin
                            case (in_byte)
                                CMD_GET_PARAM: phase_next = PH_PARAM_ARG;
                                CMD_SET_DEV:
                                begin
                                    dp_cmd.op = OP_SET_ARG;
                                    dp_cmd.arg_value = SKIP_SET_DEV;
                                    phase_next = PH_SKIP_PLAIN;
                                end
                                CMD_SET_DEV_EXT:
                                begin
                                    dp_cmd.op = OP_SET_ARG;
                                    dp_cmd.arg_value = SKIP_SET_DEV_EXT;
                                    phase_next = PH_SKIP_PLAIN;
                                end
                                CMD_UNIVERSAL:
                                begin
                                    dp_cmd.op = OP_SET_ARG;
                                    dp_cmd.arg_value = SKIP_UNIV;
                                    phase_next = PH_SKIP_UNIV;
                                end
                                CMD_LOAD_ADDR: phase_next = PH_LOAD_LO;
                                CMD_PROG_PAGE: phase_next = PH_PROG_HI;
                                CMD_READ_PAGE: phase_next = PH_READ_HI;
                                CMD_READ_SIGN: phase_next = PH_SYNC_SIGN;
                                CMD_LEAVE:
                                begin
                                    ov_next = 1'b1; act_next = ACT_WDT; send_next = '0;
                                    addr_next = '0; word_next = '0; last_next = 1'b1;
                                    phase_next = PH_SYNC_LEAVE;
                                end
                                default: phase_next = PH_SYNC_PLAIN;
                            endcase
                        end
                        PH_PARAM_ARG:
                            phase_next = (in_byte == PARM_MAJOR || in_byte == PARM_MINOR)
                                         ? PH_SYNC_YES : PH_SYNC_NO;
                        PH_SKIP_PLAIN, PH_SKIP_UNIV:
                        begin
                            dp_cmd.op = OP_ARG_DEC;
                            if (status.arg == 8'd1)
                                phase_next = (ph == PH_SKIP_PLAIN) ? PH_SYNC_PLAIN
                                                                   : PH_SYNC_UNIV;
                        end
                        PH_LOAD_LO:
                        begin
                            dp_cmd.op = OP_ARG_LOAD;
                            phase_next = PH_LOAD_HI;
                        end
                        PH_LOAD_HI:
                        begin
                            dp_cmd.op = OP_CURSOR_LOAD;
                            phase_next = PH_SYNC_PLAIN;
                        end
                        PH_PROG_HI: phase_next = PH_PROG_LO;
                        PH_PROG_LO:
                        begin
                            dp_cmd.op = OP_PAGE_LEN;
                            phase_next = PH_PROG_MEM;
                        end
                        PH_PROG_MEM:
                        begin
                            dp_cmd.op = OP_ERASE_START;
                            ov_next = 1'b1; act_next = ACT_ERASE; send_next = '0;
                            addr_next = status.cursor; word_next = '0; last_next = 1'b1;
                            phase_next = (status.page_length == 8'd0) ? PH_SYNC_PROG
                                                                       : PH_PROG_DATA;
                        end
                        PH_PROG_DATA:
                        begin
                            dp_cmd.op = OP_STORE;
                            if (status.arg_next_eq_len)
                                phase_next = PH_SYNC_PROG;
                        end
                        PH_READ_HI: phase_next = PH_READ_CNT;
                        PH_READ_CNT:
                        begin
                            dp_cmd.op = OP_READ_CNT;
                            phase_next = PH_READ_MEM;
                        end
                        PH_READ_MEM: phase_next = PH_SYNC_READ;
                        PH_READ_STREAM: ;
                        default:
                        begin
                            if (in_byte != EOP_BYTE)
                            begin
                                ov_next = 1'b1; act_next = ACT_WDT; send_next = '0;
                                addr_next = '0; word_next = '0; last_next = 1'b1;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                ov_next = 1'b1; act_next = ACT_SEND;
                                send_next = RESP_INSYNC; addr_next = '0;
                                word_next = '0; last_next = 1'b0;
                                case (phase_reg)
                                    PH_SYNC_YES:
                                    begin
                                        val_next = VAL_PARAM_YES; em_next = EM_VAL;
                                    end
                                    PH_SYNC_NO:
                                    begin
                                        val_next = VAL_PARAM_NO; em_next = EM_VAL;
                                    end
                                    PH_SYNC_UNIV:
                                    begin
                                        val_next = VAL_UNIV; em_next = EM_VAL;
                                    end
                                    PH_SYNC_SIGN:
                                    begin
                                        val_next = sig_first; em_next = EM_SIG2;
                                    end
                                    PH_SYNC_PROG:
                                    begin
                                        dp_cmd.op = OP_FILL_START; em_next = EM_FILL;
                                    end
                                    PH_SYNC_READ: em_next = EM_READ;
                                    default: em_next = EM_OK;
                                endcase
                            end
                        end
                    endcase
                end
            end
        end
        else if (space)
        begin
            ov_next = 1'b1; send_next = '0; addr_next = '0; word_next = '0;
            last_next = 1'b0; act_next = ACT_SEND;
            case (em_reg)
                EM_VAL:
                begin
                    send_next = val_reg; em_next = EM_OK;
                end
                EM_SIG2:
                begin
                    send_next = val_reg; val_next = sig_second; em_next = EM_SIG3;
                end
                EM_SIG3:
                begin
                    send_next = val_reg; val_next = sig_third; em_next = EM_VAL;
                end
                EM_FILL:
                begin
                    act_next = ACT_FILL; addr_next = status.fill_address;
                    word_next = status.fill_word; dp_cmd.op = OP_FILL_NEXT;
                    if (status.fill_done)
                        em_next = EM_WRITE;
                end
                EM_WRITE:
                begin
                    act_next = ACT_WRITE; addr_next = status.cursor; em_next = EM_RWW;
                end
                EM_RWW:
                begin
                    act_next = ACT_RWW; em_next = EM_OK;
                end
                EM_OK:
                begin
                    send_next = RESP_OK; last_next = 1'b1; em_next = EM_IDLE;
                    if (phase_reg == PH_SYNC_LEAVE)
                        halted_next = 1'b1;
                    phase_next = PH_CMD;
                end
                EM_READ:
                begin
                    act_next = ACT_READ; addr_next = status.cursor; last_next = 1'b1;
                    dp_cmd.op = OP_CURSOR_INC; phase_next = PH_READ_STREAM;
                    em_next = EM_IDLE;
                end
                EM_FLASH:
                begin
                    send_next = fbyte_reg; dp_cmd.op = OP_READ_DEC;
                    em_next = (status.read_remaining == 8'd1) ? EM_OK : EM_READ;
                end
                default: em_next = EM_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CMD;
            em_reg     <= EM_IDLE;
            halted_reg <= 1'b0;
            ov_reg     <= 1'b0;
            act_reg    <= ACT_SEND;
            send_reg   <= '0;
            addr_reg   <= '0;
            word_reg   <= '0;
            last_reg   <= 1'b0;
            val_reg    <= '0;
            fbyte_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            em_reg     <= em_next;
            halted_reg <= halted_next;
            ov_reg     <= ov_next;
            act_reg    <= act_next;
            send_reg   <= send_next;
            addr_reg   <= addr_next;
            word_reg   <= word_next;
            last_reg   <= last_next;
            val_reg    <= val_next;
            fbyte_reg  <= fbyte_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_action = act_reg;
    assign out_send   = send_reg;
    assign out_addr   = addr_reg;
    assign out_word   = word_reg;
    assign out_last   = last_reg;
endmodule

### rtl/serial_flash_loader_protocol.sv
// Protocol engine: one transaction in per received or flash byte; results out
// one per cycle while the consumer is ready. A byte that causes results
// is not followed by another until all its results have gone out.
`timescale 1ns / 1ps
module serial_flash_loader_protocol
    import sflp_pkg::*;
#(
    parameter int PAGE_BYTES = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [7:0]  send_value,
    output logic [15:0] flash_address,
    output logic [15:0] fill_word,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    dp_cmd_t    dp_cmd;
    dp_status_t status;
    logic [7:0] sig1_reg, sig2_reg, sig3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig1_reg <= 8'd30;
            sig2_reg <= 8'd149;
            sig3_reg <= 8'd15;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIG_FIRST:  sig1_reg <= cfg_data;
                REG_SIG_SECOND: sig2_reg <= cfg_data;
                REG_SIG_THIRD:  sig3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sflp_controller u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready,
        .in_cmd(cmd), .in_byte(data_byte),
        .sig_first(sig1_reg), .sig_second(sig2_reg), .sig_third(sig3_reg),
        .status, .dp_cmd, .out_valid, .out_ready,
        .out_action(action), .out_send(send_value), .out_addr(flash_address),
        .out_word(fill_word), .out_last(last)
    );

    sflp_datapath #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
        .clk, .rst_n, .cmd_in(dp_cmd), .byte_in(data_byte), .status
    );
endmodule

### rtl/sflp_checker.sv
// Port-level checker for the protocol engine, bound to the top level.
// Depends on sflp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "serial_flash_loader_protocol_macros.svh"
module sflp_port_checker
    import sflp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  action,
    input logic [7:0]  send_value,
    input logic [15:0] fill_word,
    input logic        last
);
    `SFL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(action) && $stable(send_value), "stalled result changed")
    `SFL_ASSERT_IMP(a_action_range, clk, rst_n, out_valid, action != 3'd7, "bad action code")
    `SFL_ASSERT_IMP(a_no_take_busy, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
    `SFL_ASSERT_IMP(a_fill_word_zero, clk, rst_n, out_valid && action != ACT_FILL, fill_word == 16'd0, "fill word set off fill")
    `SFL_ASSERT_IMP(a_single_last, clk, rst_n, out_valid && (action == ACT_WDT || action == ACT_ERASE), last, "lone result not marked last")
endmodule

bind serial_flash_loader_protocol sflp_port_checker u_chk (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready,
    .action, .send_value, .fill_word, .last
);
